>>> hdl/qte_pkg.sv
// shared types and constants for the quaternion to euler angle converter
package qte_pkg;

  // widths of the internal terms
  localparam int TERM_W  = 34;   // sum-of-products terms, Q4.28 with headroom
  localparam int SARG_W  = 30;   // clamped pitch argument
  localparam int ROOT_W  = 58;   // square root work registers
  localparam int CX_W    = 36;   // cordic x and y
  localparam int ANG_W   = 34;   // cordic angle, Q4.30
  localparam int SQRT_STEPS = 29;
  localparam int LANES   = 3;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [16:0] PI_Q13      = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;

  // atan(2^-i) in Q2.30
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127
  };

  // one cordic lane
  typedef struct packed {
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;
  } lane_t;

  // terms carried alongside the square root
  typedef struct packed {
    logic signed [TERM_W-1:0] rn;
    logic signed [TERM_W-1:0] rd;
    logic signed [TERM_W-1:0] yn;
    logic signed [TERM_W-1:0] yd;
    logic signed [SARG_W-1:0] s;
  } side_t;

endpackage

>>> hdl/qte_sqrt_cell.sv
// one step of the bitwise integer square root, with the terms that ride along
module qte_sqrt_cell
  import qte_pkg::*;
#(
  parameter int BIT_POS = 56
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W-1:0] n_in,
  input  logic [ROOT_W-1:0] res_in,
  input  side_t             side_in,
  output logic [ROOT_W-1:0] n_out,
  output logic [ROOT_W-1:0] res_out,
  output side_t             side_out
);

  logic [ROOT_W-1:0] bitv;
  logic [ROOT_W-1:0] trial;
  logic [ROOT_W-1:0] n_next;
  logic [ROOT_W-1:0] res_next;

  // trial subtract of res + bit
  always_comb begin
    bitv  = ROOT_W'(1) << BIT_POS;
    trial = res_in + bitv;
    if (n_in >= trial) begin
      n_next   = n_in - trial;
      res_next = (res_in >> 1) + bitv;
    end else begin
      n_next   = n_in;
      res_next = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out    <= n_next;
      res_out  <= res_next;
      side_out <= side_in;
    end
  end

endmodule

>>> hdl/qte_cordic_cell.sv
// one vectoring micro-rotation for the three angle lanes
module qte_cordic_cell
  import qte_pkg::*;
#(
  parameter int ITER = 0
) (
  input  logic  clk,
  input  logic  en,
  input  lane_t lane_in  [LANES],
  output lane_t lane_out [LANES]
);

  lane_t lane_next [LANES];

  // rotate toward the x axis
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_next[k].zero = lane_in[k].zero;
      if (lane_in[k].y >= 0) begin
        lane_next[k].x = lane_in[k].x + (lane_in[k].y >>> ITER);
        lane_next[k].y = lane_in[k].y - (lane_in[k].x >>> ITER);
        lane_next[k].z = lane_in[k].z + ANG_W'(ATAN_TAB[ITER]);
      end else begin
        lane_next[k].x = lane_in[k].x - (lane_in[k].y >>> ITER);
        lane_next[k].y = lane_in[k].y + (lane_in[k].x >>> ITER);
        lane_next[k].z = lane_in[k].z - ANG_W'(ATAN_TAB[ITER]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

>>> hdl/quaternion_to_euler_angles.sv
// top level: quaternion to roll, pitch and yaw, fully pipelined
//
// Input channel: quat_w, quat_x, quat_y, quat_z (signed Q2.14) with
// in_valid / in_ready. Output channel: roll_angle, yaw_angle (16-bit, signed
// Q3.13) and pitch_angle (15-bit, signed Q2.13), in radians, with out_valid / out_ready.
// A word is moved when valid and ready are both high at a clock edge.
//
// One quaternion is accepted every cycle unless the output stalls. Each
// result passes through the product, clamping and squaring stages, 29
// square root cells, one pre-rotation stage, one cordic cell per
// iteration and an output stage.
// The square root cells set most of the latency.
//
// Reset (rst, synchronous) clears all valid bits; the data path holds no
// state worth clearing. When the receiver stalls with a word waiting, the
// whole pipeline freezes and in_ready drops in the same cycle.
module quaternion_to_euler_angles
  import qte_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle
);

  localparam int STAGES = 3 + SQRT_STEPS + 1 + ANGLE_ITERATIONS + 1;
  localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd268435456);
  localparam logic signed [TERM_W-1:0] NEG_ONE_Q28 = -ONE_Q28;

  logic en;
  logic [STAGES-1:0] vld;

  // stage 1: products
  logic signed [31:0] pwx, pyz, pxx, pyy, pwz, pxy, pzz, pwy, pzx;
  // stage 2: terms
  side_t terms;
  logic signed [TERM_W-1:0] s_raw;
  // stage 3: square of the pitch argument
  side_t terms3;
  logic signed [2*SARG_W-1:0] ssq;

  // square root chain
  logic [ROOT_W-1:0] rn_chain  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] res_chain [SQRT_STEPS+1];
  side_t             side_chain [SQRT_STEPS+1];

  // cordic chain
  lane_t pre_in   [LANES];
  lane_t cchain   [ANGLE_ITERATIONS+1][LANES];

  logic signed [16:0] q_roll, q_pitch, q_yaw;

  assign en       = !vld[STAGES-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[STAGES-1];

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      pwx <= quat_w * quat_x;
      pyz <= quat_y * quat_z;
      pxx <= quat_x * quat_x;
      pyy <= quat_y * quat_y;
      pwz <= quat_w * quat_z;
      pxy <= quat_x * quat_y;
      pzz <= quat_z * quat_z;
      pwy <= quat_w * quat_y;
      pzx <= quat_z * quat_x;
    end
  end

  // sums of products and pitch clamp
  always_comb begin
    s_raw = (TERM_W'(pwy) - TERM_W'(pzx)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms.rn <= (TERM_W'(pwx) + TERM_W'(pyz)) <<< 1;
      terms.rd <= ONE_Q28 - ((TERM_W'(pxx) + TERM_W'(pyy)) <<< 1);
      terms.yn <= (TERM_W'(pwz) + TERM_W'(pxy)) <<< 1;
      terms.yd <= ONE_Q28 - ((TERM_W'(pyy) + TERM_W'(pzz)) <<< 1);
      if (s_raw > ONE_Q28) begin
        terms.s <= SARG_W'(ONE_Q28);
      end else if (s_raw < NEG_ONE_Q28) begin
        terms.s <= SARG_W'(NEG_ONE_Q28);
      end else begin
        terms.s <= SARG_W'(s_raw);
      end
    end
  end

  // square of the clamped argument
  always_ff @(posedge clk) begin
    if (en) begin
      ssq    <= terms.s * terms.s;
      terms3 <= terms;
    end
  end

  assign rn_chain[0]   = (ROOT_W'(1) << 56) - ROOT_W'(ssq[56:0]);
  assign res_chain[0]  = '0;
  assign side_chain[0] = terms3;

  // square root cells
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    qte_sqrt_cell #(
      .BIT_POS(56 - 2 * k)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .n_in    (rn_chain[k]),
      .res_in  (res_chain[k]),
      .side_in (side_chain[k]),
      .n_out   (rn_chain[k+1]),
      .res_out (res_chain[k+1]),
      .side_out(side_chain[k+1])
    );
  end

  // lane inputs: roll, pitch, yaw
  always_comb begin
    pre_in[0] = '{x: CX_W'(side_chain[SQRT_STEPS].rd), y: CX_W'(side_chain[SQRT_STEPS].rn),
                  z: '0, zero: 1'b0};
    pre_in[1] = '{x: CX_W'({1'b0, res_chain[SQRT_STEPS][28:0]}),
                  y: CX_W'(side_chain[SQRT_STEPS].s), z: '0, zero: 1'b0};
    pre_in[2] = '{x: CX_W'(side_chain[SQRT_STEPS].yd), y: CX_W'(side_chain[SQRT_STEPS].yn),
                  z: '0, zero: 1'b0};
  end

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        cchain[0][k].zero <= (pre_in[k].x == 0) && (pre_in[k].y == 0);
        if (pre_in[k].x < 0) begin
          if (pre_in[k].y >= 0) begin
            cchain[0][k].x <= pre_in[k].y;
            cchain[0][k].y <= -pre_in[k].x;
            cchain[0][k].z <= HALF_PI_Q30;
          end else begin
            cchain[0][k].x <= -pre_in[k].y;
            cchain[0][k].y <= pre_in[k].x;
            cchain[0][k].z <= -HALF_PI_Q30;
          end
        end else begin
          cchain[0][k].x <= pre_in[k].x;
          cchain[0][k].y <= pre_in[k].y;
          cchain[0][k].z <= '0;
        end
      end
    end
  end

  // cordic cells
  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
    qte_cordic_cell #(
      .ITER(i)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .lane_in (cchain[i]),
      .lane_out(cchain[i+1])
    );
  end

  // round to Q3.13
  always_comb begin
    q_roll  = 17'((cchain[ANGLE_ITERATIONS][0].z + ANG_W'(65536)) >>> 17);
    q_pitch = 17'((cchain[ANGLE_ITERATIONS][1].z + ANG_W'(65536)) >>> 17);
    q_yaw   = 17'((cchain[ANGLE_ITERATIONS][2].z + ANG_W'(65536)) >>> 17);
  end

  // output register with clamp and zero case
  always_ff @(posedge clk) begin
    if (en) begin
      if (cchain[ANGLE_ITERATIONS][0].zero) begin
        roll_angle <= '0;
      end else if (q_roll > PI_Q13) begin
        roll_angle <= 16'(PI_Q13);
      end else if (q_roll < -PI_Q13) begin
        roll_angle <= 16'(-PI_Q13);
      end else begin
        roll_angle <= 16'(q_roll);
      end
      if (cchain[ANGLE_ITERATIONS][1].zero) begin
        pitch_angle <= '0;
      end else if (q_pitch > HALF_PI_Q13) begin
        pitch_angle <= 15'(HALF_PI_Q13);
      end else if (q_pitch < -HALF_PI_Q13) begin
        pitch_angle <= 15'(-HALF_PI_Q13);
      end else begin
        pitch_angle <= 15'(q_pitch);
      end
      if (cchain[ANGLE_ITERATIONS][2].zero) begin
        yaw_angle <= '0;
      end else if (q_yaw > PI_Q13) begin
        yaw_angle <= 16'(PI_Q13);
      end else if (q_yaw < -PI_Q13) begin
        yaw_angle <= 16'(-PI_Q13);
      end else begin
        yaw_angle <= 16'(q_yaw);
      end
    end
  end

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(roll_angle) && $stable(yaw_angle)
      && $stable(pitch_angle))
    else $error("result changed while stalled");

  // pipeline advances whenever the last stage is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow the output stage");

  // pitch stays within a quarter turn
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

endmodule
